// ----- rtl/assert_macros.svh -----
// Assertion macros used by the LCD nibble interface back end.
// No dependencies; the including module supplies clk_i and rst_ni in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CLNI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define CLNI_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CLNI_ASSERT(lbl, prop)
`define CLNI_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/clni_pkg.sv -----
// Types, codes and constant tables for the character LCD nibble interface.
// No dependencies.
package clni_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam logic [3:0]  INIT_LAST   = 4'd9;
  localparam logic [3:0]  NIB_WAKE    = 4'h3;
  localparam logic [3:0]  NIB_FOUR    = 4'h2;
  localparam logic [7:0]  CURSOR_CMD  = 8'h80;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_INIT   = 3'd1,
    OP_CMD    = 3'd2,
    OP_DATA   = 3'd3,
    OP_CURSOR = 3'd4
  } op_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POWER_UP_WAIT = 2'd0,
    REG_COMMAND_WAIT  = 2'd1,
    REG_DATA_WAIT     = 2'd2,
    REG_ENABLE_PULSE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_INIT,
    KIND_BYTE
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWER,
    PH_NIB_EN,
    PH_BYTE_EN,
    PH_GAP,
    PH_WAIT
  } phase_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [6:0] column;
  } in_t;

  typedef struct packed {
    logic       lcd_rs;
    logic       lcd_en;
    logic [3:0] lcd_nibble;
    logic       busy_res;
    logic       rejected;
  } out_t;

  // classified word passed from front to back
  typedef struct packed {
    kind_e      kind;
    logic       sel;
    logic [7:0] value;
  } word_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] power_up_wait;
    logic [CFG_DATA_W-1:0] command_wait;
    logic [CFG_DATA_W-1:0] data_wait;
    logic [7:0]            enable_pulse;
  } cfg_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h28;
      3'd1:    r = 8'h08;
      3'd2:    r = 8'h06;
      3'd3:    r = 8'h0C;
      default: r = 8'h01;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] line_base(input logic [1:0] row);
    logic [6:0] r;
    unique case (row)
      2'd0:    r = 7'h00;
      2'd1:    r = 7'h40;
      2'd2:    r = 7'h14;
      default: r = 7'h54;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/clni_front.sv -----
// Front end: decodes a request word and forms the byte to send.
// Depends on clni_pkg.
module clni_front (
  input  clni_pkg::in_t   in_data_i,
  output clni_pkg::word_t word_o
);

  logic [6:0] addr;

  assign addr = 7'(clni_pkg::line_base(in_data_i.row) + in_data_i.column);

  always_comb begin
    word_o.kind  = clni_pkg::KIND_TICK;
    word_o.sel   = 1'b0;
    word_o.value = in_data_i.byte_value;
    unique case (in_data_i.op)
      clni_pkg::OP_INIT: word_o.kind = clni_pkg::KIND_INIT;
      clni_pkg::OP_CMD:  word_o.kind = clni_pkg::KIND_BYTE;
      clni_pkg::OP_DATA: begin
        word_o.kind = clni_pkg::KIND_BYTE;
        word_o.sel  = 1'b1;
      end
      clni_pkg::OP_CURSOR: begin
        word_o.kind  = clni_pkg::KIND_BYTE;
        word_o.value = clni_pkg::CURSOR_CMD | {1'b0, addr};
      end
      default: word_o.kind = clni_pkg::KIND_TICK;
    endcase
  end

endmodule

// ----- rtl/clni_fifo.sv -----
// Two-entry queue of classified words between front and back.
// Depends on clni_pkg.
module clni_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  clni_pkg::word_t push_word_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output clni_pkg::word_t pop_word_o
);

  clni_pkg::word_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  assign ready_o    = (count_q != 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_word_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= 2'(count_q + {1'b0, push_i} - {1'b0, pop_i});
    end
  end

endmodule

// ----- rtl/clni_back.sv -----
// Back end: LCD sequencer stepped once per word, with the result register.
// Depends on clni_pkg and assert_macros.svh.
`include "assert_macros.svh"
module clni_back #(
  parameter int unsigned WAIT_WIDTH = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clni_pkg::cfg_t  cfg_i,
  input  logic            word_valid_i,
  input  clni_pkg::word_t word_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output clni_pkg::out_t  out_data_o
);

  clni_pkg::phase_e      phase_q, phase_d;
  logic [3:0]            step_q, step_d, step_inc;
  logic [WAIT_WIDTH-1:0] wait_q, wait_d, wait_dec;
  logic [WAIT_WIDTH-1:0] w_power, w_cmd, w_data, w_pulse;
  logic [7:0]            pend_q, pend_d;
  logic                  psel_q, psel_d;
  logic                  second_q, second_d;
  logic                  rs_q, rs_d;
  logic                  en_q, en_d;
  logic [3:0]            nib_q, nib_d;
  logic                  out_valid_q;
  clni_pkg::out_t        out_q, out_d;
  logic                  pop, done, rej;
  logic [7:0]            init_byte;
  logic                  strobe_phase;

  assign pop         = word_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign w_power   = WAIT_WIDTH'(cfg_i.power_up_wait);
  assign w_cmd     = WAIT_WIDTH'(cfg_i.command_wait);
  assign w_data    = WAIT_WIDTH'(cfg_i.data_wait);
  assign w_pulse   = WAIT_WIDTH'(cfg_i.enable_pulse);
  assign done      = (wait_q <= WAIT_WIDTH'(1));
  assign wait_dec  = done ? '0 : wait_q - WAIT_WIDTH'(1);
  assign step_inc  = step_q + 4'd1;
  assign init_byte = clni_pkg::init_cmd(3'(step_inc - 4'd5));
  assign rej       = (phase_q != clni_pkg::PH_IDLE) && (word_i.kind != clni_pkg::KIND_TICK);
  assign strobe_phase = (phase_q == clni_pkg::PH_NIB_EN) || (phase_q == clni_pkg::PH_BYTE_EN);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (pop) begin
      unique case (phase_q)
        clni_pkg::PH_IDLE: begin
          unique case (word_i.kind)
            clni_pkg::KIND_INIT: phase_d = clni_pkg::PH_POWER;
            clni_pkg::KIND_BYTE: phase_d = clni_pkg::PH_BYTE_EN;
            default:             phase_d = clni_pkg::PH_IDLE;
          endcase
        end
        clni_pkg::PH_POWER:   if (done) phase_d = clni_pkg::PH_NIB_EN;
        clni_pkg::PH_NIB_EN:  if (done) phase_d = clni_pkg::PH_WAIT;
        clni_pkg::PH_BYTE_EN: begin
          if (done) phase_d = second_q ? clni_pkg::PH_WAIT : clni_pkg::PH_GAP;
        end
        clni_pkg::PH_GAP:     phase_d = clni_pkg::PH_BYTE_EN;
        clni_pkg::PH_WAIT: begin
          if (done) begin
            priority if (step_q == 4'd0)            phase_d = clni_pkg::PH_IDLE;
            else if (step_inc <= 4'd4)              phase_d = clni_pkg::PH_NIB_EN;
            else if (step_inc <= clni_pkg::INIT_LAST) phase_d = clni_pkg::PH_BYTE_EN;
            else                                    phase_d = clni_pkg::PH_IDLE;
          end
        end
        default: phase_d = clni_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath and pin updates
  always_comb begin
    step_d   = step_q;
    wait_d   = wait_q;
    pend_d   = pend_q;
    psel_d   = psel_q;
    second_d = second_q;
    rs_d     = rs_q;
    en_d     = en_q;
    nib_d    = nib_q;
    if (pop) begin
      unique case (phase_q)
        clni_pkg::PH_IDLE: begin
          if (word_i.kind == clni_pkg::KIND_INIT) begin
            step_d = 4'd0;
            en_d   = 1'b0;
            wait_d = w_power;
          end else if (word_i.kind == clni_pkg::KIND_BYTE) begin
            pend_d   = word_i.value;
            psel_d   = word_i.sel;
            second_d = 1'b0;
            rs_d     = word_i.sel;
            nib_d    = word_i.value[7:4];
            en_d     = 1'b1;
            wait_d   = w_pulse;
          end
        end
        clni_pkg::PH_POWER: begin
          wait_d = wait_dec;
          if (done) begin
            step_d = 4'd1;
            rs_d   = 1'b0;
            nib_d  = clni_pkg::NIB_WAKE;
            en_d   = 1'b1;
            wait_d = w_pulse;
          end
        end
        clni_pkg::PH_NIB_EN: begin
          wait_d = wait_dec;
          if (done) begin
            en_d   = 1'b0;
            wait_d = w_cmd;
          end
        end
        clni_pkg::PH_BYTE_EN: begin
          wait_d = wait_dec;
          if (done) begin
            en_d = 1'b0;
            if (second_q) wait_d = psel_q ? w_data : w_cmd;
          end
        end
        clni_pkg::PH_GAP: begin
          second_d = 1'b1;
          nib_d    = pend_q[3:0];
          en_d     = 1'b1;
          wait_d   = w_pulse;
        end
        clni_pkg::PH_WAIT: begin
          wait_d = wait_dec;
          if (done && (step_q != 4'd0)) begin
            step_d = step_inc;
            priority if (step_inc <= 4'd4) begin
              rs_d   = 1'b0;
              nib_d  = (step_inc == 4'd4) ? clni_pkg::NIB_FOUR : clni_pkg::NIB_WAKE;
              en_d   = 1'b1;
              wait_d = w_pulse;
            end else if (step_inc <= clni_pkg::INIT_LAST) begin
              pend_d   = init_byte;
              psel_d   = 1'b0;
              second_d = 1'b0;
              rs_d     = 1'b0;
              nib_d    = init_byte[7:4];
              en_d     = 1'b1;
              wait_d   = w_pulse;
            end else begin
              step_d = 4'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_d = '{lcd_rs:     rs_d,
                   lcd_en:     en_d,
                   lcd_nibble: nib_d,
                   busy_res:   (phase_d != clni_pkg::PH_IDLE),
                   rejected:   rej};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= clni_pkg::PH_IDLE;
      step_q      <= 4'd0;
      wait_q      <= '0;
      pend_q      <= 8'd0;
      psel_q      <= 1'b0;
      second_q    <= 1'b0;
      rs_q        <= 1'b0;
      en_q        <= 1'b0;
      nib_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      step_q   <= step_d;
      wait_q   <= wait_d;
      pend_q   <= pend_d;
      psel_q   <= psel_d;
      second_q <= second_d;
      rs_q     <= rs_d;
      en_q     <= en_d;
      nib_q    <= nib_d;
      if (pop)              out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) out_q <= out_d;
  end

  `CLNI_ASSERT(a_en_in_strobe, en_q |-> strobe_phase)
  `CLNI_ASSERT(a_hold_no_pop, !pop |=> $stable(phase_q) && $stable(wait_q))
  `CLNI_NEVER(a_gap_first_half, phase_q == clni_pkg::PH_GAP && second_q)
  `CLNI_NEVER(a_step_range, step_q > clni_pkg::INIT_LAST)

endmodule

// ----- rtl/char_lcd_nibble_interface.sv -----
// Top level of the character LCD 4-bit bus interface: config registers,
// front decode, word queue and back sequencer. Depends on clni_pkg and modules.
//
//  channel | dir | handshake                 | word
//  in      | in  | in_valid_i / in_ready_o   | clni_pkg::in_t (op, byte, row, column)
//  out     | out | out_valid_o / out_ready_i | clni_pkg::out_t (pins, busy, rejected)
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle while the output is not stalled; a word's result is registered
// at the edge it leaves the two-entry queue.
// The sequencer advances one step per word; timing is counted in words.
// Reset clears the sequencer to idle and restores the register defaults.
// Either side may stall; the queue and output register decouple them.
module char_lcd_nibble_interface #(
  parameter int unsigned WAIT_WIDTH = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  clni_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output clni_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [clni_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [clni_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  clni_pkg::cfg_t  cfg_q;
  clni_pkg::word_t front_word, queue_word;
  logic            queue_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_up_wait <= 24'd100000;
      cfg_q.command_wait  <= 24'd5000;
      cfg_q.data_wait     <= 24'd50;
      cfg_q.enable_pulse  <= 8'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        clni_pkg::REG_POWER_UP_WAIT: cfg_q.power_up_wait <= cfg_data_i;
        clni_pkg::REG_COMMAND_WAIT:  cfg_q.command_wait  <= cfg_data_i;
        clni_pkg::REG_DATA_WAIT:     cfg_q.data_wait     <= cfg_data_i;
        clni_pkg::REG_ENABLE_PULSE:  cfg_q.enable_pulse  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  clni_front u_front (
    .in_data_i (in_data_i),
    .word_o    (front_word)
  );

  clni_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && in_ready_o),
    .push_word_i (front_word),
    .ready_o     (in_ready_o),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .pop_word_o  (queue_word)
  );

  clni_back #(
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .word_valid_i (queue_valid),
    .word_i       (queue_word),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
